// File: src/hilbert_curve_index_converter_assert.svh
// Assertion macros for the Hilbert index converter.
// Both sample on clk_i and are quiet while rst_ni is low.
`ifndef HILBERT_CURVE_INDEX_CONVERTER_ASSERT_SVH
`define HILBERT_CURVE_INDEX_CONVERTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HCIC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcic check failed");

// consequent must hold in the cycle after the antecedent
`define HCIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcic check failed");

`endif

// File: src/hcic_pkg.sv
package hcic_pkg;

  // conversion direction, as held in the configuration register
  typedef enum logic {
    DIR_TO_INDEX = 1'b0,
    DIR_TO_AXES  = 1'b1
  } hcic_dir_e;

  // the port list always carries three axis coordinates
  localparam int unsigned MAX_AXES = 3;

endpackage

// File: src/hilbert_curve_index_converter.sv
// An input transfer passes stage registers 0..B-1, then the output register.
// One transfer per cycle either way unless stalled; one register stage per bit level.
// Stalls collapse bubbles stage by stage, so input is taken while a result waits.
// Reset (rst_ni low, async) empties every stage and sets direction to axes-to-index.
`include "hilbert_curve_index_converter_assert.svh"

module hilbert_curve_index_converter import hcic_pkg::*; #(
  parameter int unsigned BITS_PER_AXIS = 5,
  parameter int unsigned NUM_AXES      = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: the direction register
  input  logic                                dir_we_i,
  input  logic                                dir_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [BITS_PER_AXIS-1:0]            axis_zero_i,
  input  logic [BITS_PER_AXIS-1:0]            axis_one_i,
  input  logic [BITS_PER_AXIS-1:0]            axis_two_i,
  input  logic [BITS_PER_AXIS*NUM_AXES-1:0]   curve_index_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [BITS_PER_AXIS-1:0]            result_axis_zero_o,
  output logic [BITS_PER_AXIS-1:0]            result_axis_one_o,
  output logic [BITS_PER_AXIS-1:0]            result_axis_two_o,
  output logic [BITS_PER_AXIS*NUM_AXES-1:0]   result_index_o
);

  localparam int unsigned IndexW     = BITS_PER_AXIS * NUM_AXES;
  // stage 0 loads the words, stages 1..B-1 each do one bit level
  localparam int unsigned NUM_STAGES = BITS_PER_AXIS;
  localparam logic [BITS_PER_AXIS-1:0] AXIS_ONES = '1;

  typedef logic [BITS_PER_AXIS-1:0] axis_t;

  // ---------------------------------------------------------------------------
  // Direction register
  // ---------------------------------------------------------------------------
  hcic_dir_e dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_TO_INDEX;
    end else if (dir_we_i) begin
      dir_q <= hcic_dir_e'(dir_wdata_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline storage. Each item carries its own direction down the pipe.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_q;
  hcic_dir_e             mode_q [NUM_STAGES];
  axis_t                 w_q    [NUM_STAGES][NUM_AXES];
  axis_t                 w_in_d [NUM_AXES];
  axis_t                 w_d    [1:NUM_STAGES-1][NUM_AXES];

  logic                  out_valid_q;
  axis_t                 res_axis_q [NUM_AXES];
  axis_t                 res_axis_d [NUM_AXES];
  logic [IndexW-1:0]     res_index_q;
  logic [IndexW-1:0]     res_index_d;

  // stage_en[s]: stage s may load this cycle; top entry is the output register
  logic [NUM_STAGES:0]   stage_en;

  always_comb begin
    stage_en[NUM_STAGES] = !out_valid_q || !out_stall_i;
    for (int s = NUM_STAGES - 1; s >= 0; s--) begin
      stage_en[s] = !v_q[s] || stage_en[s+1];
    end
  end

  assign in_stall_o = !stage_en[0];

  // ---------------------------------------------------------------------------
  // Stage 0: take the coordinates, or unpack the index and undo its Gray code
  // ---------------------------------------------------------------------------
  always_comb begin
    axis_t in_axes [MAX_AXES];
    axis_t u       [NUM_AXES];
    axis_t top;
    in_axes[0] = axis_zero_i;
    in_axes[1] = axis_one_i;
    in_axes[2] = axis_two_i;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < BITS_PER_AXIS; k++) begin
        // axis 0 is the most significant bit of each group
        u[a][k] = curve_index_i[k*NUM_AXES + NUM_AXES - 1 - a];
      end
    end
    top = u[NUM_AXES-1] >> 1;
    if (dir_q == DIR_TO_INDEX) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        w_in_d[a] = in_axes[a];
      end
    end else begin
      w_in_d[0] = u[0] ^ top;
      for (int a = 1; a < NUM_AXES; a++) begin
        w_in_d[a] = u[a] ^ u[a-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..B-1: one invert/exchange level each.
  // Forward walks the levels top down, inverse bottom up.
  // ---------------------------------------------------------------------------
  always_comb begin
    axis_t t [NUM_AXES];
    axis_t low;
    axis_t sw;
    low = '0;
    sw  = '0;
    for (int s = 1; s < NUM_STAGES; s++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        t[a] = w_q[s-1][a];
      end
      if (mode_q[s-1] == DIR_TO_INDEX) begin
        low = AXIS_ONES >> s;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (t[a][BITS_PER_AXIS-s]) begin
            t[0] = t[0] ^ low;
          end else begin
            sw   = (t[0] ^ t[a]) & low;
            t[0] = t[0] ^ sw;
            t[a] = t[a] ^ sw;
          end
        end
      end else begin
        low = AXIS_ONES >> (BITS_PER_AXIS - s);
        for (int a = NUM_AXES - 1; a > 0; a--) begin
          if (t[a][s]) begin
            t[0] = t[0] ^ low;
          end else begin
            sw   = (t[0] ^ t[a]) & low;
            t[0] = t[0] ^ sw;
            t[a] = t[a] ^ sw;
          end
        end
        if (t[0][s]) begin
          t[0] = t[0] ^ low;
        end
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        w_d[s][a] = t[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (stage_en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (stage_en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      mode_q[0] <= dir_q;
      w_q[0]    <= w_in_d;
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (stage_en[s]) begin
        mode_q[s] <= mode_q[s-1];
        w_q[s]    <= w_d[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: forward does Gray encode, the lower-bit flip and packing;
  // inverse passes the words straight out. The unused side reads zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    axis_t g [NUM_AXES];
    axis_t acc;
    g[0] = w_q[NUM_STAGES-1][0];
    for (int a = 1; a < NUM_AXES; a++) begin
      g[a] = w_q[NUM_STAGES-1][a] ^ g[a-1];
    end
    // each bit flips by the parity of the last word's bits above it
    for (int i = 0; i < BITS_PER_AXIS; i++) begin
      acc[i] = ^(g[NUM_AXES-1] >> (i + 1));
    end
    res_index_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      res_axis_d[a] = '0;
    end
    if (mode_q[NUM_STAGES-1] == DIR_TO_INDEX) begin
      for (int k = 0; k < BITS_PER_AXIS; k++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          res_index_d[k*NUM_AXES + NUM_AXES - 1 - a] = g[a][k] ^ acc[k];
        end
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        res_axis_d[a] = w_q[NUM_STAGES-1][a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_en[NUM_STAGES]) begin
      out_valid_q <= v_q[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[NUM_STAGES]) begin
      res_axis_q  <= res_axis_d;
      res_index_q <= res_index_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_axis_zero_o = res_axis_q[0];
  assign result_axis_one_o  = res_axis_q[1];
  // with two axes the third coordinate does not exist
  assign result_axis_two_o  = (NUM_AXES > 2) ? res_axis_q[NUM_AXES-1] : '0;
  assign result_index_o     = res_index_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // input is refused only when the whole pipe is backed up behind a held result
  `HCIC_ASSERT_SAME(a_stall_only_when_full, in_stall_o, (&v_q) && out_valid_o && out_stall_i)
  // a transfer in always lands in the first stage
  `HCIC_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, v_q[0])
  // one side of every result is zero
  `HCIC_ASSERT_SAME(a_unused_side_zero, out_valid_o,
    (result_index_o == '0) || ((result_axis_zero_o == '0) && (result_axis_one_o == '0)
    && (result_axis_two_o == '0)))

endmodule
